/* rtl/variable_width_bit_reader_defines.svh */
// Assertion macros shared by the variable-width bit reader modules.
`ifndef VARIABLE_WIDTH_BIT_READER_DEFINES_SVH
`define VARIABLE_WIDTH_BIT_READER_DEFINES_SVH

`ifndef SYNTHESIS
`define VWBR_ASSERT_ALWAYS(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
`define VWBR_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define VWBR_ASSERT_ALWAYS(label, cond, msg)
`define VWBR_ASSERT_NEXT(label, ante, cons, msg)
`endif

`endif

/* rtl/vwbr_pkg.sv */
// Package with the types and constants of the variable-width bit reader.
`timescale 1ns / 1ps

package vwbr_pkg;

    localparam int STORE_BYTES = 4096;
    localparam int ADDR_W      = $clog2(STORE_BYTES);
    localparam int COUNT_W     = 13;
    localparam int POS_W       = 16;
    localparam int MAX_BITS    = 32;
    localparam int FETCH_BYTES = 5;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_EOS  = 2'd1;
    localparam logic [1:0] ST_FULL = 2'd2;

    localparam logic OP_APPEND = 1'b0;
    localparam logic OP_READ   = 1'b1;

    localparam logic MODE_MSB_BYTES = 1'b0;
    localparam logic MODE_LSB_WORDS = 1'b1;

    typedef struct packed {
        logic       op;
        logic [7:0] data_byte;
        logic [5:0] bit_count;
    } item_t;

    typedef struct packed {
        logic [31:0]        value;
        logic [POS_W-1:0]   bits_consumed;
        logic [COUNT_W-1:0] bytes_held;
        logic [1:0]         status;
    } result_t;

    typedef struct packed {
        logic       load;
        logic       append;
        logic       reject;
        logic       fetch;
        logic       finish_read;
        logic [2:0] fetch_idx;
    } ctl_t;

    typedef struct packed {
        logic is_append;
        logic bad;
        logic zero_width;
    } stat_t;

endpackage

/* rtl/vwbr_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module vwbr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

/* rtl/vwbr_datapath.sv */
// Datapath of the bit reader: byte store, counters, byte window and bit packing.
`timescale 1ns / 1ps
`include "variable_width_bit_reader_defines.svh"

module vwbr_datapath import vwbr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  item_t   item,
    input  logic    cfg_we,
    input  logic    cfg_data,
    input  ctl_t    ctl,
    output stat_t   stat,
    output result_t result
);

    item_t              item_reg;
    logic               mode_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COUNT_W-1:0] count_next;
    logic [POS_W-1:0]   pos_reg;
    logic [POS_W-1:0]   pos_next;
    result_t            result_reg;
    result_t            result_next;
    logic               pending_reg;
    logic [8*FETCH_BYTES-1:0] window_reg;

    logic               full;
    logic [COUNT_W-1:0] readable_bytes;
    logic [POS_W-1:0]   readable_bits;
    logic [POS_W:0]     end_pos;
    logic [ADDR_W-1:0]  base_addr;
    logic [ADDR_W-1:0]  raddr;
    logic [7:0]         rdata;
    logic               we;
    logic [2:0]         off;
    logic [31:0]        top_bits;
    logic [31:0]        msb_value;
    logic [8*FETCH_BYTES-1:0] le_window;
    logic [8*FETCH_BYTES-1:0] le_shifted;
    logic [31:0]        lsb_mask;
    logic [31:0]        lsb_value;

    assign full           = (count_reg == COUNT_W'(STORE_BYTES));
    assign readable_bytes = (mode_reg == MODE_LSB_WORDS) ? {count_reg[COUNT_W-1:2], 2'b00}
                                                         : count_reg;
    assign readable_bits  = {readable_bytes, 3'b000};
    assign end_pos        = {1'b0, pos_reg} + (POS_W+1)'(item_reg.bit_count);

    assign stat.is_append  = (item_reg.op == OP_APPEND);
    assign stat.bad        = (item_reg.bit_count > 6'(MAX_BITS))
                             || (end_pos > {1'b0, readable_bits});
    assign stat.zero_width = (item_reg.bit_count == 6'd0);

    assign base_addr = pos_reg[ADDR_W+2:3];
    assign raddr     = base_addr + ADDR_W'(ctl.fetch_idx);
    assign we        = ctl.append && !full;

    vwbr_ram #(
        .WIDTH(8),
        .DEPTH(STORE_BYTES)
    ) u_store (
        .clk  (clk),
        .we   (we),
        .waddr(count_reg[ADDR_W-1:0]),
        .wdata(item_reg.data_byte),
        .raddr(raddr),
        .rdata(rdata)
    );

    // Mode 0 reads the window as a big-endian bit string, mode 1 as a little-endian word.
    assign off        = pos_reg[2:0];
    assign top_bits   = window_reg[(6'd39 - {3'b000, off}) -: 32];
    assign msb_value  = top_bits >> (6'd32 - item_reg.bit_count);
    assign le_window  = {window_reg[7:0], window_reg[15:8], window_reg[23:16],
                         window_reg[31:24], window_reg[39:32]};
    assign le_shifted = le_window >> off;
    assign lsb_mask   = ~(32'hFFFF_FFFF << item_reg.bit_count);
    assign lsb_value  = le_shifted[31:0] & lsb_mask;

    always_comb
    begin
        count_next  = count_reg;
        pos_next    = pos_reg;
        result_next = result_reg;
        if (ctl.append)
        begin
            if (!full)
            begin
                count_next = count_reg + COUNT_W'(1);
            end
            result_next.value         = 32'd0;
            result_next.bits_consumed = pos_reg;
            result_next.bytes_held    = count_next;
            result_next.status        = full ? ST_FULL : ST_OK;
        end
        else if (ctl.reject)
        begin
            result_next.value         = 32'd0;
            result_next.bits_consumed = pos_reg;
            result_next.bytes_held    = count_reg;
            result_next.status        = ST_EOS;
        end
        else if (ctl.finish_read)
        begin
            pos_next                  = end_pos[POS_W-1:0];
            result_next.value         = (mode_reg == MODE_LSB_WORDS) ? lsb_value : msb_value;
            result_next.bits_consumed = pos_next;
            result_next.bytes_held    = count_reg;
            result_next.status        = ST_OK;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_MSB_BYTES;
            count_reg   <= '0;
            pos_reg     <= '0;
            pending_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                mode_reg <= cfg_data;
            end
            count_reg   <= count_next;
            pos_reg     <= pos_next;
            pending_reg <= ctl.fetch;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctl.load)
        begin
            item_reg <= item;
        end
        if (pending_reg)
        begin
            window_reg <= {window_reg[8*FETCH_BYTES-9:0], rdata};
        end
        result_reg <= result_next;
    end

    assign result = result_reg;

    `VWBR_ASSERT_ALWAYS(a_count_bound, count_reg <= COUNT_W'(STORE_BYTES), "byte count too large")
    `VWBR_ASSERT_ALWAYS(a_pos_bound, pos_reg <= {count_reg, 3'b000}, "bit position past the data")
    `VWBR_ASSERT_NEXT(a_pos_hold, !ctl.finish_read, $stable(pos_reg), "position moved off a read")

endmodule

/* rtl/vwbr_ctrl.sv */
// Controller state machine of the bit reader: sequences appends, checks and byte fetches.
`timescale 1ns / 1ps
`include "variable_width_bit_reader_defines.svh"

module vwbr_ctrl import vwbr_pkg::*; (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  start,
    input  stat_t stat,
    output ctl_t  ctl,
    output logic  busy,
    output logic  done
);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_CHECK = 3'd1;
    localparam logic [2:0] S_FETCH = 3'd2;
    localparam logic [2:0] S_DRAIN = 3'd3;
    localparam logic [2:0] S_PACK  = 3'd4;
    localparam logic [2:0] S_DONE  = 3'd5;

    localparam logic [2:0] LAST_IDX = 3'(FETCH_BYTES - 1);

    logic [2:0] state_reg;
    logic [2:0] state_next;
    logic [2:0] idx_reg;
    logic [2:0] idx_next;

    always_comb
    begin
        state_next = state_reg;
        idx_next   = idx_reg;
        ctl        = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    ctl.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (stat.is_append)
                begin
                    ctl.append = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.bad)
                begin
                    ctl.reject = 1'b1;
                    state_next = S_DONE;
                end
                else if (stat.zero_width)
                begin
                    ctl.finish_read = 1'b1;
                    state_next      = S_DONE;
                end
                else
                begin
                    ctl.fetch     = 1'b1;
                    ctl.fetch_idx = 3'd0;
                    idx_next      = 3'd1;
                    state_next    = S_FETCH;
                end
            end
            S_FETCH:
            begin
                ctl.fetch     = 1'b1;
                ctl.fetch_idx = idx_reg;
                idx_next      = idx_reg + 3'd1;
                if (idx_reg == LAST_IDX)
                begin
                    state_next = S_DRAIN;
                end
            end
            S_DRAIN:
            begin
                state_next = S_PACK;
            end
            S_PACK:
            begin
                ctl.finish_read = 1'b1;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            idx_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
        end
    end

    assign busy = (state_reg != S_IDLE);
    assign done = (state_reg == S_DONE);

    `VWBR_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "accepted transfer did not raise busy")
    `VWBR_ASSERT_NEXT(a_done_idle, done, !busy, "controller not idle after a result")
    `VWBR_ASSERT_ALWAYS(a_fetch_busy, !ctl.fetch || busy, "byte fetch issued while idle")

endmodule

/* rtl/variable_width_bit_reader.sv */
// Top level of the variable-width bit reader: controller, datapath and configuration port.
//
// An item is a transfer taken at a rising edge with start high and busy low. With op
// append, data_byte is stored at the end of the byte store unless the store is full;
// with op read, bit_count bits (0 to 32) are taken from the running bit position and
// packed per the bit order mode. Every item gives exactly one result, shown on result
// for one cycle with done high; the receiver cannot stall it and must take it in that cycle.
// An append, a refused read and a zero-width read go from the check state straight to
// the done state, where done is high. A read of 1 to 32 bits passes the check, fetch,
// drain and pack states before done: five byte fetches go one per cycle through the
// single read port of the byte store, the drain state waits for the last byte, then the
// pack state packs the bits. Busy stays high until the controller is idle again.
// The bit order mode is written through cfg_valid/cfg_ready/cfg_data; cfg_ready is high
// whenever busy is low. Reset clears the byte count, the bit position and the mode; the
// store content is not cleared and needs no clearing pass.

`timescale 1ns / 1ps

module variable_width_bit_reader import vwbr_pkg::*; (
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  item_t   item,
    output logic    busy,
    output logic    done,
    output result_t result,
    input  logic    cfg_valid,
    output logic    cfg_ready,
    input  logic    cfg_data
);

    ctl_t  ctl;
    stat_t stat;

    assign cfg_ready = !busy;

    vwbr_ctrl u_ctrl (
        .clk  (clk),
        .rst_n(rst_n),
        .start(start),
        .stat (stat),
        .ctl  (ctl),
        .busy (busy),
        .done (done)
    );

    vwbr_datapath u_datapath (
        .clk     (clk),
        .rst_n   (rst_n),
        .item    (item),
        .cfg_we  (cfg_valid && cfg_ready),
        .cfg_data(cfg_data),
        .ctl     (ctl),
        .stat    (stat),
        .result  (result)
    );

endmodule
